/* rtl/stdp_pkg.sv */
// ----------------------------------------------------------------------------
// stdp_pkg
// Shared constants, word types and the decay table builder for the STDP
// synapse weight update unit.
// ----------------------------------------------------------------------------
package stdp_pkg;

    localparam int SYNAPSES      = 256;
    localparam int ADDR_W        = $clog2(SYNAPSES);
    localparam int DECAY_ENTRIES = 2048;
    localparam int DECAY_W       = $clog2(DECAY_ENTRIES);
    localparam int DECAY_TAU_MS  = 20;
    localparam int TICKS_PER_MS  = 16;

    localparam logic [15:0] WEIGHT_ONE   = 16'd32768;
    localparam logic [15:0] WEIGHT_RESET = 16'd16384;

    localparam logic [15:0] POT_GAIN_RESET = 16'd328;
    localparam logic [15:0] DEP_GAIN_RESET = 16'd393;
    localparam logic [10:0] WINDOW_RESET   = 11'd1600;

    localparam int CFG_IDX_W = 2;

    // exp(-1/tau) by the alternating series in q62, tau in ticks
    localparam logic [63:0] DECAY_T = 64'(DECAY_TAU_MS * TICKS_PER_MS);
    localparam logic [63:0] SER_1   = (64'd1 << 62) / DECAY_T;
    localparam logic [63:0] SER_2   = SER_1 / (64'd2 * DECAY_T);
    localparam logic [63:0] SER_3   = SER_2 / (64'd3 * DECAY_T);
    localparam logic [63:0] SER_4   = SER_3 / (64'd4 * DECAY_T);
    localparam logic [63:0] SER_5   = SER_4 / (64'd5 * DECAY_T);
    localparam logic [63:0] SER_6   = SER_5 / (64'd6 * DECAY_T);
    localparam logic [63:0] SER_7   = SER_6 / (64'd7 * DECAY_T);
    localparam logic [63:0] SER_8   = SER_7 / (64'd8 * DECAY_T);
    localparam logic [63:0] SER_9   = SER_8 / (64'd9 * DECAY_T);
    localparam logic [63:0] SER_10  = SER_9 / (64'd10 * DECAY_T);
    localparam logic [63:0] SER_11  = SER_10 / (64'd11 * DECAY_T);
    localparam logic [63:0] SER_12  = SER_11 / (64'd12 * DECAY_T);
    localparam logic [63:0] SER_13  = SER_12 / (64'd13 * DECAY_T);
    localparam logic [63:0] SER_14  = SER_13 / (64'd14 * DECAY_T);
    localparam logic [63:0] SER_15  = SER_14 / (64'd15 * DECAY_T);
    localparam logic [63:0] SER_16  = SER_15 / (64'd16 * DECAY_T);
    localparam logic [63:0] SER_17  = SER_16 / (64'd17 * DECAY_T);
    localparam logic [63:0] SER_18  = SER_17 / (64'd18 * DECAY_T);
    localparam logic [63:0] SER_19  = SER_18 / (64'd19 * DECAY_T);
    localparam logic [63:0] SER_20  = SER_19 / (64'd20 * DECAY_T);
    localparam logic [63:0] SER_ACC = (64'd1 << 62)
        - SER_1 + SER_2 - SER_3 + SER_4 - SER_5 + SER_6 - SER_7 + SER_8
        - SER_9 + SER_10 - SER_11 + SER_12 - SER_13 + SER_14 - SER_15 + SER_16
        - SER_17 + SER_18 - SER_19 + SER_20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POT_GAIN = 2'd0,
        CFG_DEP_GAIN = 2'd1,
        CFG_WINDOW   = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        SPK_PRE  = 1'b0,
        SPK_POST = 1'b1
    } t_spike;

    typedef enum logic {
        ST_OK        = 1'b0,
        ST_BAD_INDEX = 1'b1
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic        mode;
        logic [15:0] synapse_index;
        logic [31:0] event_time;
    } t_in_word;

    typedef struct packed {
        logic        status;
        logic [15:0] addressed_weight;
        logic [31:0] event_count;
    } t_out_word;

    typedef struct packed {
        logic [31:0] pre_time;
        logic [15:0] weight;
    } t_syn_entry;

    typedef struct packed {
        logic       valid;
        t_syn_entry entry;
    } t_syn_rd;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_syn_entry        entry;
    } t_syn_wr;

    typedef struct packed {
        logic              vld;
        logic              last;
        t_spike            op;
        logic [ADDR_W-1:0] addr;
    } t_issue;

    typedef struct packed {
        logic              vld;
        logic              last;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       weight;
    } t_wb;

    typedef logic [15:0] t_decay_rom [DECAY_ENTRIES];

    // exp(-d/tau) in q0.16, built at elaboration
    function automatic t_decay_rom f_build_decay_rom();
        logic [63:0] r32;
        logic [63:0] e;
        logic [63:0] v;
        t_decay_rom  rom;
        r32 = (SER_ACC + (64'd1 << 29)) >> 30;
        if (r32 > 64'hFFFF_FFFF) begin
            r32 = 64'hFFFF_FFFF;
        end
        e = 64'd1 << 32;
        for (int d = 0; d < DECAY_ENTRIES; d++) begin
            v      = (e + 64'd32768) >> 16;
            rom[d] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
            e      = (e * r32 + (64'd1 << 31)) >> 32;
        end
        return rom;
    endfunction

endpackage

/* rtl/stdp_syn_mem.sv */
// ----------------------------------------------------------------------------
// stdp_syn_mem
// Synapse entry memory: pre spike time and weight per synapse, one write and
// one registered read per cycle, with a valid flag per entry.
// ----------------------------------------------------------------------------
module stdp_syn_mem
    import stdp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  t_syn_wr           i_wr,
    output t_syn_rd           o_rd
);

    t_syn_entry            r_mem [SYNAPSES];
    logic [SYNAPSES-1:0]   r_valid;
    t_syn_entry            r_rd_entry;
    logic                  r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
        r_rd_entry <= r_mem[i_rd_addr];
        r_rd_valid <= r_valid[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // a never written entry reads as the reset weight
    always_comb begin
        o_rd.valid          = r_rd_valid;
        o_rd.entry.pre_time = r_rd_entry.pre_time;
        o_rd.entry.weight   = r_rd_valid ? r_rd_entry.weight : WEIGHT_RESET;
    end

endmodule

/* rtl/stdp_decay_rom.sv */
// ----------------------------------------------------------------------------
// stdp_decay_rom
// Decay table exp(-dt/tau) in q0.16 with a registered read.
// ----------------------------------------------------------------------------
module stdp_decay_rom
    import stdp_pkg::*;
(
    input  logic               i_clk,
    input  logic [DECAY_W-1:0] i_addr,
    output logic [15:0]        o_data
);

    localparam t_decay_rom DECAY_TABLE = f_build_decay_rom();

    logic [15:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= DECAY_TABLE[i_addr];
    end

    assign o_data = r_data;

endmodule

/* rtl/stdp_update_dp.sv */
// ----------------------------------------------------------------------------
// stdp_update_dp
// Read-modify-write datapath: time difference and window test, decay lookup,
// gain multiply, clamped weight update and write back.
// ----------------------------------------------------------------------------
module stdp_update_dp
    import stdp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_issue             i_issue,
    input  t_syn_rd            i_rd,
    input  logic [15:0]        i_rom_data,
    input  logic [15:0]        i_pot_gain,
    input  logic [15:0]        i_dep_gain,
    input  logic [10:0]        i_window,
    input  logic [31:0]        i_now,
    input  logic [31:0]        i_post_time,
    input  logic               i_post_seen,
    output logic [DECAY_W-1:0] o_rom_addr,
    output t_syn_wr            o_wr,
    output t_wb                o_wb
);

    t_issue      r_s1;
    t_issue      r_s2;
    t_issue      r_s3;
    logic        r_s2_en;
    logic        r_s3_en;
    logic [15:0] r_s2_weight;
    logic [15:0] r_s3_weight;
    logic [31:0] r_s2_pre_time;
    logic [31:0] r_s3_pre_time;
    logic [31:0] r_s3_prod;

    logic [31:0] s1_dt;
    logic        s1_en;
    logic [31:0] s2_prod;
    logic [32:0] s3_round;
    logic [16:0] s3_delta;
    logic [17:0] s3_inc;
    logic [16:0] s3_dec;
    logic [15:0] s3_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else begin
            r_s1 <= i_issue;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
        end
    end

    // stage 1: memory data back
    always_comb begin
        if (r_s1.op == SPK_POST) begin
            s1_dt = i_now - i_rd.entry.pre_time;
        end else begin
            s1_dt = i_now - i_post_time;
        end
        s1_en = (s1_dt != 32'd0) && (s1_dt < 32'(i_window))
              && (s1_dt < 32'(DECAY_ENTRIES))
              && ((r_s1.op == SPK_POST) ? i_rd.valid : i_post_seen);
    end

    assign o_rom_addr = s1_dt[DECAY_W-1:0];

    always_ff @(posedge i_clk) begin
        r_s2_en       <= s1_en;
        r_s2_weight   <= i_rd.entry.weight;
        r_s2_pre_time <= i_rd.entry.pre_time;
    end

    // stage 2: gain times decay
    assign s2_prod = ((r_s2.op == SPK_POST) ? i_pot_gain : i_dep_gain) * i_rom_data;

    always_ff @(posedge i_clk) begin
        r_s3_en       <= r_s2_en;
        r_s3_weight   <= r_s2_weight;
        r_s3_pre_time <= r_s2_pre_time;
        r_s3_prod     <= s2_prod;
    end

    // stage 3: round, clamp, write back
    always_comb begin
        s3_round = {1'b0, r_s3_prod} + 33'd32768;
        s3_delta = s3_round[32:16];
        s3_inc   = 18'(r_s3_weight) + 18'(s3_delta);
        s3_dec   = 17'(r_s3_weight) - s3_delta;
        if (!r_s3_en) begin
            s3_weight = r_s3_weight;
        end else if (r_s3.op == SPK_POST) begin
            s3_weight = (s3_inc > 18'(WEIGHT_ONE)) ? WEIGHT_ONE : s3_inc[15:0];
        end else begin
            s3_weight = (17'(r_s3_weight) > s3_delta) ? s3_dec[15:0] : 16'd0;
        end
    end

    always_comb begin
        o_wr.en             = r_s3.vld && ((r_s3.op == SPK_PRE) || r_s3_en);
        o_wr.addr           = r_s3.addr;
        o_wr.entry.pre_time = (r_s3.op == SPK_PRE) ? i_now : r_s3_pre_time;
        o_wr.entry.weight   = s3_weight;
        o_wb.vld            = r_s3.vld;
        o_wb.last           = r_s3.last;
        o_wb.addr           = r_s3.addr;
        o_wb.weight         = s3_weight;
    end

endmodule

/* rtl/stdp_synapse_weight_update_unit.sv */
// ----------------------------------------------------------------------------
// stdp_synapse_weight_update_unit
// Pair-based STDP weight update over a synapse memory, one result word per
// event word.
// ----------------------------------------------------------------------------
// One event is handled at a time. A pre spike reads, updates and writes back
// its own synapse entry; a post spike walks every entry of the synapse
// memory, one entry per cycle through the read, decay lookup, multiply and
// write back stages. When the last write back is done the result word goes
// to the pending slot and then to the output register, and the next event
// can be taken once the pending slot is empty. An event with an index beyond
// the synapse count answers through the same slot and changes nothing. A
// result word waiting at the output does not hold off the next event, but
// one that must wait in the pending slot does. No clearing pass is needed
// after reset.
module stdp_synapse_weight_update_unit
    import stdp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_word,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output t_out_word            o_res_word
);

    t_state            r_state;
    t_state            n_state;
    logic [15:0]       r_pot_gain;
    logic [15:0]       r_dep_gain;
    logic [10:0]       r_window;
    t_spike            r_op;
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] r_addr;
    logic [31:0]       r_now;
    logic [31:0]       r_post_time;
    logic              r_post_seen;
    logic [31:0]       r_count;
    logic [15:0]       r_hit_weight;
    logic              r_pend_vld;
    t_out_word         r_pend_word;
    logic              r_res_vld;
    t_out_word         r_res_word;

    logic               accept;
    logic               in_range;
    logic               out_free;
    logic               done;
    t_issue             issue;
    t_syn_rd            syn_rd;
    t_syn_wr            syn_wr;
    t_wb                wb;
    logic [DECAY_W-1:0] rom_addr;
    logic [15:0]        rom_data;
    logic [15:0]        done_weight;

    assign in_range = 32'(i_in_word.synapse_index) < SYNAPSES;
    assign accept   = i_in_valid && o_in_ready;
    assign done     = wb.vld && wb.last;
    assign out_free = !r_res_vld || i_res_ready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pot_gain <= POT_GAIN_RESET;
            r_dep_gain <= DEP_GAIN_RESET;
            r_window   <= WINDOW_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_POT_GAIN: r_pot_gain <= i_cfg_data;
                CFG_DEP_GAIN: r_dep_gain <= i_cfg_data;
                CFG_WINDOW:   r_window   <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && in_range) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (issue.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        issue      = '0;
        issue.op   = r_op;
        issue.addr = r_addr;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = !r_pend_vld;
            end
            S_ISSUE: begin
                issue.vld  = 1'b1;
                issue.last = (r_op == SPK_PRE) || (r_addr == ADDR_W'(SYNAPSES - 1));
            end
            S_DRAIN: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_post_seen <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state <= n_state;
            if (accept && in_range) begin
                r_count <= r_count + 32'd1;
                if (t_spike'(i_in_word.mode) == SPK_POST) begin
                    r_post_seen <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && in_range) begin
            r_op   <= t_spike'(i_in_word.mode);
            r_idx  <= i_in_word.synapse_index[ADDR_W-1:0];
            r_now  <= i_in_word.event_time;
            r_addr <= (t_spike'(i_in_word.mode) == SPK_POST)
                    ? '0 : i_in_word.synapse_index[ADDR_W-1:0];
            if (t_spike'(i_in_word.mode) == SPK_POST) begin
                r_post_time <= i_in_word.event_time;
            end
        end else if (issue.vld) begin
            r_addr <= r_addr + ADDR_W'(1);
        end
        if (wb.vld && (wb.addr == r_idx)) begin
            r_hit_weight <= wb.weight;
        end
    end

    assign done_weight = (wb.addr == r_idx) ? wb.weight : r_hit_weight;

    // result words: pending slot then output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_res_vld  <= 1'b0;
        end else begin
            if ((accept && !in_range) || done) begin
                r_pend_vld <= 1'b1;
            end else if (out_free) begin
                r_pend_vld <= 1'b0;
            end
            if (out_free) begin
                r_res_vld <= r_pend_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !in_range) begin
            r_pend_word.status           <= ST_BAD_INDEX;
            r_pend_word.addressed_weight <= '0;
            r_pend_word.event_count      <= r_count;
        end else if (done) begin
            r_pend_word.status           <= ST_OK;
            r_pend_word.addressed_weight <= done_weight;
            r_pend_word.event_count      <= r_count;
        end
        if (out_free) begin
            r_res_word <= r_pend_word;
        end
    end

    assign o_res_valid = r_res_vld;
    assign o_res_word  = r_res_word;

    stdp_syn_mem u_syn_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (issue.addr),
        .i_wr      (syn_wr),
        .o_rd      (syn_rd)
    );

    stdp_decay_rom u_decay_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    stdp_update_dp u_update_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_rd        (syn_rd),
        .i_rom_data  (rom_data),
        .i_pot_gain  (r_pot_gain),
        .i_dep_gain  (r_dep_gain),
        .i_window    (r_window),
        .i_now       (r_now),
        .i_post_time (r_post_time),
        .i_post_seen (r_post_seen),
        .o_rom_addr  (rom_addr),
        .o_wr        (syn_wr),
        .o_wb        (wb)
    );

    a_no_wb_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !wb.vld)
        else $error("write back while idle");

    a_last_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> (r_state == S_DRAIN))
        else $error("final write back outside drain");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_range) |=> (r_count == $past(r_count) + 32'd1))
        else $error("event count not advanced");

    a_bad_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !in_range) |=> (r_pend_vld && (r_state == S_IDLE)))
        else $error("bad index not answered at once");

endmodule
